// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes for the periodic task table
// Command and result item layouts, slot record, ring control, state codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// command modes
	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_DEL  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_DUE  = 2'd2;
	localparam logic [1:0] KIND_IDLE = 2'd3;

	// most due tasks served by one tick
	localparam logic [4:0] MAX_DUE = 5'h10;

	// reported live count saturates here
	localparam logic [4:0] LIVE_MAX = 5'd31;

	typedef struct packed {
		logic        [1:0]  mode;
		logic        [15:0] task_id;
		logic        [15:0] period;
		logic        [15:0] delay;
		logic signed [31:0] now;
	} ptt_in_t;

	typedef struct packed {
		logic        [1:0]  kind;
		logic        [15:0] task_id_res;
		logic        [3:0]  slot_index;
		logic signed [31:0] elapsed;
		logic               ok;
		logic        [4:0]  live_count;
		logic               last;
	} ptt_out_t;

	// one table slot; task id zero marks it empty
	typedef struct packed {
		logic [15:0] task_id;
		logic [15:0] period;
		logic [31:0] deadline;
	} ptt_slot_t;

	// ring control from the scan controller to the cell chain
	typedef struct packed {
		logic      shift;
		ptt_slot_t feed;
	} ptt_ring_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} ptt_state_t;

endpackage

// ===== hdl/ptt_cell.sv =====
// ----------------------------------------------------------------------------
// ptt_cell: one slot of the task ring
// Holds a slot record, loads its neighbor's record on shift, and flags
// whether it holds the id on the compare bus.
// ----------------------------------------------------------------------------
module ptt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  ptt_pkg::ptt_slot_t nxt,
	input  logic [15:0]       id,
	output ptt_pkg::ptt_slot_t slot,
	output logic              match
);

	ptt_pkg::ptt_slot_t slot_q;

	// load the neighbor's record while the ring rotates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= nxt;
		end
	end

	assign slot  = slot_q;
	assign match = (slot_q.task_id == id);

endmodule

// ===== hdl/ptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptt_ctrl: scan controller at the head of the task ring
// Sequences one full rotation per item, edits the head slot, and
// issues result items one at a time.
// ----------------------------------------------------------------------------
module ptt_ctrl #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ptt_pkg::ptt_in_t   cmd,
	output logic               busy,
	input  ptt_pkg::ptt_slot_t head,
	input  logic [SLOTS-1:0]   match,
	output ptt_pkg::ptt_ring_t ring,
	output logic               strobe,
	output ptt_pkg::ptt_out_t  result
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int LIVE_MAX_I = 31;

	ptt_pkg::ptt_state_t state_q, state_d;
	ptt_pkg::ptt_in_t    op_q;
	ptt_pkg::ptt_out_t   res_q, pend_q, due_rec, final_rec;
	logic [IW-1:0]       idx_q, fidx_q;
	logic [CW-1:0]       cnt_q;
	logic [4:0]          n_q;
	logic [4:0]          live;
	logic [31:0]         last_tick_q;
	logic                any_q, skip_q, done_q, pend_v_q, strobe_q;
	logic                accept, add_hit, del_hit, due_hit;

	// saturate the live count for reporting
	assign live = (32'(cnt_q) > 32'(LIVE_MAX_I)) ? ptt_pkg::LIVE_MAX : 5'(cnt_q);

	assign accept = start && (state_q == ptt_pkg::ST_IDLE) &&
		(cmd.mode == ptt_pkg::MODE_ADD || cmd.mode == ptt_pkg::MODE_DEL ||
		 cmd.mode == ptt_pkg::MODE_TICK);

	// decide what happens to the slot at the head of the ring
	always_comb begin
		add_hit = (state_q == ptt_pkg::ST_SCAN) && (op_q.mode == ptt_pkg::MODE_ADD) &&
			(op_q.task_id != 16'd0) && !done_q &&
			(any_q ? (head.task_id == op_q.task_id) : (head.task_id == 16'd0));
		del_hit = (state_q == ptt_pkg::ST_SCAN) && (op_q.mode == ptt_pkg::MODE_DEL) &&
			(op_q.task_id != 16'd0) && !done_q && (head.task_id == op_q.task_id);
		due_hit = (state_q == ptt_pkg::ST_SCAN) && (op_q.mode == ptt_pkg::MODE_TICK) &&
			!skip_q && (head.task_id != 16'd0) && (n_q < ptt_pkg::MAX_DUE) &&
			($signed(head.deadline) <= op_q.now);

		ring.shift = (state_q == ptt_pkg::ST_SCAN);
		ring.feed  = head;
		if (add_hit) begin
			ring.feed.task_id  = op_q.task_id;
			ring.feed.period   = op_q.period;
			ring.feed.deadline = 32'(op_q.now) + 32'(op_q.delay);
		end else if (del_hit) begin
			ring.feed.task_id = 16'd0;
		end else if (due_hit) begin
			ring.feed.deadline = 32'(op_q.now) + 32'(head.period);
		end
	end

	// build the due record and the closing record
	always_comb begin
		due_rec             = '0;
		due_rec.kind        = ptt_pkg::KIND_DUE;
		due_rec.task_id_res = head.task_id;
		due_rec.slot_index  = 4'(idx_q);
		due_rec.elapsed     = $signed(32'(op_q.now) - head.deadline);
		due_rec.live_count  = live;

		final_rec            = '0;
		final_rec.live_count = live;
		final_rec.last       = 1'b1;
		case (op_q.mode)
			ptt_pkg::MODE_ADD, ptt_pkg::MODE_DEL: begin
				final_rec.kind        = (op_q.mode == ptt_pkg::MODE_ADD) ?
					ptt_pkg::KIND_ADD : ptt_pkg::KIND_DEL;
				final_rec.task_id_res = op_q.task_id;
				final_rec.slot_index  = done_q ? 4'(fidx_q) : 4'd0;
				final_rec.ok          = done_q;
			end
			default: begin
				if (pend_v_q) begin
					final_rec            = pend_q;
					final_rec.live_count = live;
					final_rec.last       = 1'b1;
				end else begin
					final_rec.kind = ptt_pkg::KIND_IDLE;
				end
			end
		endcase
	end

	// advance the scan sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptt_pkg::ST_IDLE: if (accept) state_d = ptt_pkg::ST_SCAN;
			ptt_pkg::ST_SCAN: if (idx_q == IW'(SLOTS - 1)) state_d = ptt_pkg::ST_FIN;
			ptt_pkg::ST_FIN:  state_d = ptt_pkg::ST_IDLE;
			default:          state_d = ptt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the item and track the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			fidx_q      <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			last_tick_q <= '0;
			any_q       <= 1'b0;
			skip_q      <= 1'b0;
			done_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			strobe_q    <= 1'b0;
			op_q        <= '0;
		end else begin
			// pulse for a released due item or the closing item
			strobe_q <= (due_hit && pend_v_q) || (state_q == ptt_pkg::ST_FIN);
			if (accept) begin
				op_q     <= cmd;
				any_q    <= |match;
				skip_q   <= (32'(cmd.now) == last_tick_q);
				done_q   <= 1'b0;
				pend_v_q <= 1'b0;
				n_q      <= '0;
				idx_q    <= '0;
				if (cmd.mode == ptt_pkg::MODE_TICK) begin
					last_tick_q <= 32'(cmd.now);
				end
			end
			if (state_q == ptt_pkg::ST_SCAN) begin
				idx_q <= idx_q + IW'(1);
			end
			if (add_hit || del_hit) begin
				done_q <= 1'b1;
				fidx_q <= idx_q;
			end
			if (add_hit && !any_q) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (del_hit) begin
				cnt_q <= cnt_q - CW'(1);
			end
			// release the previous due item once another is found
			if (due_hit) begin
				pend_v_q <= 1'b1;
				n_q      <= n_q + 5'd1;
			end
		end
	end

	// result and pending payload
	always_ff @(posedge clk) begin
		if (due_hit) begin
			pend_q <= due_rec;
			if (pend_v_q) begin
				res_q <= pend_q;
			end
		end
		if (state_q == ptt_pkg::ST_FIN) begin
			res_q <= final_rec;
		end
	end

	assign busy   = (state_q != ptt_pkg::ST_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

	// closing item leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && res_q.last |-> state_q == ptt_pkg::ST_IDLE)
		else $error("closing item issued while scan still running");

	// only due items come out ahead of the closing one
	a_mid_due: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !res_q.last |-> res_q.kind == ptt_pkg::KIND_DUE)
		else $error("non-due item issued before the closing item");

	// occupancy never exceeds the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= SLOTS)
		else $error("live count above slot count");

	// a tick never claims a slot
	a_tick_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> op_q.mode != ptt_pkg::MODE_TICK)
		else $error("slot claimed during a tick");

	// scan finishes one full rotation before closing
	a_fin_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptt_pkg::ST_FIN |-> idx_q == IW'(SLOTS))
		else $error("ring not back in slot order at scan end");

endmodule

// ===== hdl/periodic_task_table.sv =====
// ----------------------------------------------------------------------------
// periodic_task_table: periodic task slot table with due scan
// Ring of slot cells rotated past one scan controller per item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start while busy is low; the item is taken at that
//   edge. Mode add or update writes a slot, delete clears one, tick reports
//   and re-arms each due slot, at most MAX_DUE per tick, none if now equals
//   the last tick time. Mode three is ignored and gives no result. Results
//   appear on result for one cycle each, marked by strobe; the receiver must
//   take them as they come, it cannot stall the block. An item keeps busy
//   high for one full rotation of the cell ring past the head logic, plus a
//   closing state; a new item is taken only while busy is low. Due items of
//   a tick come out during the rotation, each one once the next due slot has
//   passed the head; the last due one is held for the item marked last, which
//   comes out when busy drops. Reset empties every slot, zeroes the live
//   count and the last tick time; the table is usable once reset is released.
// ----------------------------------------------------------------------------
module periodic_task_table #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ptt_pkg::ptt_in_t  cmd,
	output logic              busy,
	output logic              strobe,
	output ptt_pkg::ptt_out_t result
);

	ptt_pkg::ptt_slot_t slots [SLOTS];
	logic [SLOTS-1:0]   match;
	ptt_pkg::ptt_ring_t ring;

	// chain of slot cells; the tail takes the edited head record
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ptt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring.shift),
			.nxt    ((i == SLOTS - 1) ? ring.feed : slots[(i + 1) % SLOTS]),
			.id     (cmd.task_id),
			.slot   (slots[i]),
			.match  (match[i])
		);
	end

	// scan controller at the head of the ring
	ptt_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.head   (slots[0]),
		.match  (match),
		.ring   (ring),
		.strobe (strobe),
		.result (result)
	);

endmodule
